// ===== rtl/rsam_pkg.sv =====
// Shared constants for the RAID stripe address mapper.
// Field widths, layout mode and extra-kind codes, register indexes, reset values.
// No dependencies.
package rsam_pkg;

    // Fixed field widths
    localparam int LOGICAL_W    = 24;
    localparam int DIVIDEND_W   = LOGICAL_W + 1;
    localparam int DISK_W       = 4;
    localparam int KIND_W       = 2;
    localparam int MODE_W       = 2;
    localparam int DISK_COUNT_W = 5;
    localparam int DISK_SIZE_W  = 21;
    localparam int DATA_COUNT_W = 25;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 25;

    // Layout modes
    localparam logic [MODE_W-1:0] MODE_MIRROR_ALL   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MIRROR_PAIRS = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DEDICATED    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_ROTATE       = 2'd3;

    // Kind of the extra location
    localparam logic [KIND_W-1:0] KIND_ALL    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MIRROR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PARITY = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISK_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISK_SIZE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_COUNT  = 2'd3;

    // Register reset values
    localparam logic [MODE_W-1:0]       RST_LAYOUT_MODE = MODE_ROTATE;
    localparam logic [DISK_COUNT_W-1:0] RST_DISK_COUNT  = 5'd3;
    localparam logic [DISK_SIZE_W-1:0]  RST_DISK_SIZE   = 21'd1048576;
    localparam logic [DATA_COUNT_W-1:0] RST_DATA_COUNT  = 25'd0;

endpackage

// ===== rtl/rsam_req_if.sv =====
// Request channel of the stripe address mapper: valid, ready, logical index.
// Depends on rsam_pkg.
interface rsam_req_if import rsam_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [LOGICAL_W-1:0] logical_index;

    modport source (output valid, output logical_index, input ready);
    modport sink   (input valid, input logical_index, output ready);
endinterface

// ===== rtl/rsam_rsp_if.sv =====
// Result channel of the stripe address mapper: valid, ready, disk locations.
// Depends on rsam_pkg.
interface rsam_rsp_if import rsam_pkg::*; #(
    parameter int OFFSET_BITS = 20
);
    logic                   valid;
    logic                   ready;
    logic                   in_range;
    logic [DISK_W-1:0]      data_disk;
    logic [OFFSET_BITS-1:0] data_offset;
    logic [KIND_W-1:0]      extra_kind;
    logic [DISK_W-1:0]      extra_disk;
    logic [OFFSET_BITS-1:0] extra_offset;

    modport source (output valid, output in_range, output data_disk, output data_offset,
                    output extra_kind, output extra_disk, output extra_offset,
                    input ready);
    modport sink   (input valid, input in_range, input data_disk, input data_offset,
                    input extra_kind, input extra_disk, input extra_offset,
                    output ready);
endinterface

// ===== rtl/rsam_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a sideband
// that travels beside the operands. Depends on rsam_pkg.
module rsam_div import rsam_pkg::*; #(
    parameter int W  = 25,
    parameter int DW = 5,
    parameter int SW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [W-1:0]  i_dividend,
    input  logic [DW-1:0] i_divisor,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [W-1:0]  o_quot,
    output logic [DW-1:0] o_rem,
    output logic [DW-1:0] o_divisor,
    output logic [SW-1:0] o_side
);

    // Stage inputs: index 0 is the module input, index g+1 the register of stage g
    logic          a_v    [W+1];
    logic [W-1:0]  a_rq   [W+1];
    logic [DW-1:0] a_rem  [W+1];
    logic [DW-1:0] a_d    [W+1];
    logic [SW-1:0] a_side [W+1];

    assign a_v[0]    = i_valid;
    assign a_rq[0]   = i_dividend;
    assign a_rem[0]  = '0;
    assign a_d[0]    = i_divisor;
    assign a_side[0] = i_side;

    for (genvar g = 0; g < W; g++) begin : g_stage
        logic [DW:0]   t;
        logic [DW:0]   diff;
        logic          ge;
        logic [DW-1:0] n_rem;
        logic [W-1:0]  n_rq;
        logic          r_v;
        logic [W-1:0]  r_rq;
        logic [DW-1:0] r_rem;
        logic [DW-1:0] r_d;
        logic [SW-1:0] r_side;

        // Shift in the next dividend bit and try to subtract the divisor
        always_comb begin
            t     = {a_rem[g], a_rq[g][W-1]};
            diff  = t - {1'b0, a_d[g]};
            ge    = (t >= {1'b0, a_d[g]});
            n_rem = ge ? diff[DW-1:0] : t[DW-1:0];
            n_rq  = {a_rq[g][W-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= a_v[g];
            end
        end

        // Payload advances with the stage, no reset needed
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rq   <= n_rq;
                r_rem  <= n_rem;
                r_d    <= a_d[g];
                r_side <= a_side[g];
            end
        end

        assign a_v[g+1]    = r_v;
        assign a_rq[g+1]   = r_rq;
        assign a_rem[g+1]  = r_rem;
        assign a_d[g+1]    = r_d;
        assign a_side[g+1] = r_side;
    end

    assign o_valid   = a_v[W];
    assign o_quot    = a_rq[W];
    assign o_rem     = a_rem[W];
    assign o_divisor = a_d[W];
    assign o_side    = a_side[W];

endmodule

// ===== rtl/rsam_obuf.sv =====
// Output register with a one-entry skid stage. The pipeline advances only
// while the skid entry is free. Depends on rsam_pkg.
module rsam_obuf import rsam_pkg::*; #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic [W-1:0] i_data,
    output logic         o_space,
    output logic         o_valid,
    output logic [W-1:0] o_data,
    input  logic         i_ready
);

    logic         r_ov;
    logic         r_sv;
    logic [W-1:0] r_od;
    logic [W-1:0] r_sd;
    logic         n_ov;
    logic         n_sv;
    logic         take;
    logic         load;
    logic         out_free;

    assign take     = r_ov & i_ready;
    assign load     = i_valid & ~r_sv;
    assign out_free = ~r_ov | take;

    // Decide where the incoming item goes: output register or skid entry
    always_comb begin
        n_ov = r_ov;
        n_sv = r_sv;
        if (r_sv) begin
            if (take) begin
                n_ov = 1'b1;
                n_sv = 1'b0;
            end
        end else if (out_free) begin
            n_ov = load;
        end else if (load) begin
            n_sv = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            r_ov <= n_ov;
            r_sv <= n_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (take) begin
                r_od <= r_sd;
            end
        end else if (out_free) begin
            if (load) begin
                r_od <= i_data;
            end
        end else if (load) begin
            r_sd <= i_data;
        end
    end

    assign o_space = ~r_sv;
    assign o_valid = r_ov;
    assign o_data  = r_od;

endmodule

// ===== rtl/raid_stripe_address_mapper_unit.sv =====
// RAID stripe address mapper: maps a logical element index to disk locations
// for mirror-all, mirrored-pairs, dedicated-parity and rotating-parity layouts.
// Usage:
//   i_req carries one logical index per item; o_rsp returns one result item
//   (in_range, data disk/offset, extra kind/disk/offset) per request, in order.
//   Configuration registers are written through i_cfg_we/i_cfg_idx/i_cfg_data
//   while the block holds no items in flight.
// Throughput: one item per cycle while i_req.ready is high. Path: each accepted item passes
//   through two chained 25-stage bit-per-stage dividers (index over stripe width,
//   then stripe over disk count) and the output register before o_rsp.valid.
// Reset: synchronous, active low; clears the pipeline and loads the register
//   defaults (rotating parity, three disks, disk size 2^20, data count zero).
// Stall: when o_rsp.ready is low the result holds in the output register and
//   one more item is caught in a skid entry; the pipeline then freezes and
//   i_req.ready drops until the skid entry drains. Nothing is lost or repeated.
// Depends on rsam_pkg, rsam_req_if, rsam_rsp_if, rsam_div and rsam_obuf.
module raid_stripe_address_mapper_unit import rsam_pkg::*; #(
    parameter int MAX_DISKS   = 16,
    parameter int OFFSET_BITS = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    rsam_req_if.sink              i_req,
    rsam_rsp_if.source            o_rsp
);

    localparam int DW = $clog2(MAX_DISKS + 1);

    typedef struct packed {
        logic                 ok;
        logic [MODE_W-1:0]    mode;
        logic [LOGICAL_W-1:0] k;
    } t_side_a;

    typedef struct packed {
        t_side_a               a;
        logic [DIVIDEND_W-1:0] quot;
        logic [DW-1:0]         rem;
    } t_side_b;

    typedef struct packed {
        logic                   in_range;
        logic [DISK_W-1:0]      data_disk;
        logic [OFFSET_BITS-1:0] data_offset;
        logic [KIND_W-1:0]      extra_kind;
        logic [DISK_W-1:0]      extra_disk;
        logic [OFFSET_BITS-1:0] extra_offset;
    } t_rsp;

    // Configuration registers
    logic [MODE_W-1:0]       r_layout_mode;
    logic [DISK_COUNT_W-1:0] r_disk_count;
    logic [DISK_SIZE_W-1:0]  r_disk_size;
    logic [DATA_COUNT_W-1:0] r_data_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layout_mode <= RST_LAYOUT_MODE;
            r_disk_count  <= RST_DISK_COUNT;
            r_disk_size   <= RST_DISK_SIZE;
            r_data_count  <= RST_DATA_COUNT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LAYOUT_MODE: r_layout_mode <= i_cfg_data[MODE_W-1:0];
                CFG_DISK_COUNT:  r_disk_count  <= i_cfg_data[DISK_COUNT_W-1:0];
                CFG_DISK_SIZE:   r_disk_size   <= i_cfg_data[DISK_SIZE_W-1:0];
                CFG_DATA_COUNT:  r_data_count  <= i_cfg_data[DATA_COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline control
    logic en;
    logic accept;

    assign i_req.ready = en;
    assign accept      = i_req.valid & en;

    // Front end: clamp disk count, range check, pick dividend and divisor
    logic [DW-1:0]         n_eff;
    logic                  f_ok;
    logic [DIVIDEND_W-1:0] f_dividend;
    logic [DW-1:0]         f_divisor;
    t_side_a               f_side;

    always_comb begin
        if (r_disk_count < DISK_COUNT_W'(2)) begin
            n_eff = DW'(2);
        end else if (int'(r_disk_count) > MAX_DISKS) begin
            n_eff = DW'(MAX_DISKS);
        end else begin
            n_eff = DW'(r_disk_count);
        end

        if (r_layout_mode == MODE_MIRROR_ALL) begin
            f_ok = DATA_COUNT_W'(i_req.logical_index) < DATA_COUNT_W'(r_disk_size);
        end else begin
            f_ok = DATA_COUNT_W'(i_req.logical_index) < r_data_count;
        end

        if (r_layout_mode == MODE_MIRROR_PAIRS) begin
            f_dividend = {i_req.logical_index, 1'b0};
            f_divisor  = n_eff;
        end else begin
            f_dividend = {1'b0, i_req.logical_index};
            f_divisor  = n_eff - DW'(1);
        end

        f_side.ok   = f_ok;
        f_side.mode = r_layout_mode;
        f_side.k    = i_req.logical_index;
    end

    // First divider: linear position over stripe width
    logic                  a_valid;
    logic [DIVIDEND_W-1:0] a_quot;
    logic [DW-1:0]         a_rem;
    logic [DW-1:0]         a_divisor;
    t_side_a               a_side;
    logic [DW-1:0]         a_n;

    rsam_div #(
        .W  (DIVIDEND_W),
        .DW (DW),
        .SW ($bits(t_side_a))
    ) u_div_a (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (accept),
        .i_dividend (f_dividend),
        .i_divisor  (f_divisor),
        .i_side     (f_side),
        .o_valid    (a_valid),
        .o_quot     (a_quot),
        .o_rem      (a_rem),
        .o_divisor  (a_divisor),
        .o_side     (a_side)
    );

    // Recover the disk count from the divisor used
    assign a_n = (a_side.mode == MODE_MIRROR_PAIRS) ? a_divisor : a_divisor + DW'(1);

    t_side_b a_to_b;
    assign a_to_b.a    = a_side;
    assign a_to_b.quot = a_quot;
    assign a_to_b.rem  = a_rem;

    // Second divider: stripe modulo disk count for parity rotation
    logic                  b_valid;
    logic [DIVIDEND_W-1:0] b_quot;
    logic [DW-1:0]         b_rem;
    logic [DW-1:0]         b_n;
    t_side_b               b_side;

    rsam_div #(
        .W  (DIVIDEND_W),
        .DW (DW),
        .SW ($bits(t_side_b))
    ) u_div_b (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (a_valid),
        .i_dividend (a_quot),
        .i_divisor  (a_n),
        .i_side     (a_to_b),
        .o_valid    (b_valid),
        .o_quot     (b_quot),
        .o_rem      (b_rem),
        .o_divisor  (b_n),
        .o_side     (b_side)
    );

    // Final mapping of quotients and remainders to disk locations
    logic [DW-1:0]         rem_inc;
    logic                  wrap;
    logic [DW-1:0]         par;
    logic [DW-1:0]         pos_skip;
    logic [DIVIDEND_W-1:0] quot_inc;
    logic                  b_unused;
    t_rsp                  m_rsp;

    assign b_unused = ^b_quot;

    always_comb begin
        rem_inc  = b_side.rem + DW'(1);
        wrap     = (rem_inc == b_n);
        quot_inc = b_side.quot + DIVIDEND_W'(1);
        par      = b_n - DW'(1) - b_rem;
        pos_skip = (b_side.rem < par) ? b_side.rem : rem_inc;
        m_rsp    = '0;
        if (b_side.a.ok) begin
            m_rsp.in_range = 1'b1;
            unique case (b_side.a.mode)
                MODE_MIRROR_ALL: begin
                    m_rsp.data_offset  = OFFSET_BITS'(b_side.a.k);
                    m_rsp.extra_kind   = KIND_ALL;
                    m_rsp.extra_offset = OFFSET_BITS'(b_side.a.k);
                end
                MODE_MIRROR_PAIRS: begin
                    m_rsp.data_disk    = DISK_W'(b_side.rem);
                    m_rsp.data_offset  = OFFSET_BITS'(b_side.quot);
                    m_rsp.extra_kind   = KIND_MIRROR;
                    m_rsp.extra_disk   = wrap ? '0 : DISK_W'(rem_inc);
                    m_rsp.extra_offset = wrap ? OFFSET_BITS'(quot_inc)
                                              : OFFSET_BITS'(b_side.quot);
                end
                MODE_DEDICATED: begin
                    m_rsp.data_disk    = DISK_W'(b_side.rem);
                    m_rsp.data_offset  = OFFSET_BITS'(b_side.quot);
                    m_rsp.extra_kind   = KIND_PARITY;
                    m_rsp.extra_disk   = DISK_W'(b_n - DW'(1));
                    m_rsp.extra_offset = OFFSET_BITS'(b_side.quot);
                end
                MODE_ROTATE: begin
                    m_rsp.data_disk    = DISK_W'(pos_skip);
                    m_rsp.data_offset  = OFFSET_BITS'(b_side.quot);
                    m_rsp.extra_kind   = KIND_PARITY;
                    m_rsp.extra_disk   = DISK_W'(par);
                    m_rsp.extra_offset = OFFSET_BITS'(b_side.quot);
                end
                default: ;
            endcase
        end
        m_rsp.in_range = m_rsp.in_range | (b_unused & 1'b0);
    end

    // Output register and skid entry
    t_rsp o_data;

    rsam_obuf #(
        .W ($bits(t_rsp))
    ) u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (b_valid),
        .i_data  (m_rsp),
        .o_space (en),
        .o_valid (o_rsp.valid),
        .o_data  (o_data),
        .i_ready (o_rsp.ready)
    );

    assign o_rsp.in_range     = o_data.in_range;
    assign o_rsp.data_disk    = o_data.data_disk;
    assign o_rsp.data_offset  = o_data.data_offset;
    assign o_rsp.extra_kind   = o_data.extra_kind;
    assign o_rsp.extra_disk   = o_data.extra_disk;
    assign o_rsp.extra_offset = o_data.extra_offset;

endmodule

// ===== test/tb.sv =====
// Testbench for raid_stripe_address_mapper_unit: drives logical indexes under
// a range of array layouts and checks every disk location against a predictor.
// Depends on rsam_pkg, rsam_req_if, rsam_rsp_if and the mapper RTL.
`timescale 1ns / 100ps

module tb;
    import rsam_pkg::*;

    localparam int MAX_DISKS   = 16;
    localparam int OFFSET_BITS = 20;
    localparam int LATENCY     = 51;
    localparam int RAND_PHASES = 12;
    localparam int PHASE_ITEMS = 100;

    typedef struct packed {
        logic                   in_range;
        logic [DISK_W-1:0]      data_disk;
        logic [OFFSET_BITS-1:0] data_offset;
        logic [KIND_W-1:0]      extra_kind;
        logic [DISK_W-1:0]      extra_disk;
        logic [OFFSET_BITS-1:0] extra_offset;
    } t_loc;

    typedef enum int {
        READY_ALWAYS,
        READY_RANDOM,
        READY_PERIODIC,
        READY_LONG
    } t_ready_mode;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = CFG_LAYOUT_MODE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    rsam_req_if                          req_if ();
    rsam_rsp_if #(.OFFSET_BITS(OFFSET_BITS)) rsp_if ();

    raid_stripe_address_mapper_unit #(
        .MAX_DISKS   (MAX_DISKS),
        .OFFSET_BITS (OFFSET_BITS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    // Register copies seen by the predictor
    logic [MODE_W-1:0]       layout_sh = RST_LAYOUT_MODE;
    logic [DISK_COUNT_W-1:0] disks_sh  = RST_DISK_COUNT;
    logic [DISK_SIZE_W-1:0]  size_sh   = RST_DISK_SIZE;
    logic [DATA_COUNT_W-1:0] count_sh  = RST_DATA_COUNT;

    logic [LOGICAL_W-1:0] index_queue[$];
    t_loc                 expected_locs[$];
    int unsigned          n_queued   = 0;
    int unsigned          n_accepted = 0;
    int unsigned          err_count  = 0;
    bit                   req_taken  = 1'b0;

    int          burst_left  = 1;
    int          gap_left    = 0;
    int          gap_max     = 0;
    int          stall_left  = 0;
    int unsigned pattern_cnt = 0;
    t_ready_mode stall_mode  = READY_ALWAYS;

    initial begin
        req_if.valid         = 1'b0;
        req_if.logical_index = '0;
        rsp_if.ready         = 1'b1;
    end

    initial begin
        forever #10 clk = ~clk;
    end

    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    // Compute the locations of one logical index under the current layout
    function automatic t_loc map_index(logic [LOGICAL_W-1:0] k);
        t_loc            r;
        longint unsigned n, kk, p, stripe, pos, par;
        r  = '0;
        kk = 64'(k);
        n  = 64'(disks_sh);
        if (n < 2) n = 2;
        if (n > MAX_DISKS) n = MAX_DISKS;
        if (layout_sh == MODE_MIRROR_ALL) begin
            if (kk < size_sh) begin
                r.in_range     = 1'b1;
                r.data_offset  = OFFSET_BITS'(kk);
                r.extra_offset = OFFSET_BITS'(kk);
            end
        end else if (kk < count_sh) begin
            r.in_range = 1'b1;
            if (layout_sh == MODE_MIRROR_PAIRS) begin
                p              = 2 * kk;
                r.data_disk    = DISK_W'(p % n);
                r.data_offset  = OFFSET_BITS'(p / n);
                r.extra_kind   = KIND_MIRROR;
                r.extra_disk   = DISK_W'((p + 1) % n);
                r.extra_offset = OFFSET_BITS'((p + 1) / n);
            end else if (layout_sh == MODE_DEDICATED) begin
                r.data_disk    = DISK_W'(kk % (n - 1));
                r.data_offset  = OFFSET_BITS'(kk / (n - 1));
                r.extra_kind   = KIND_PARITY;
                r.extra_disk   = DISK_W'(n - 1);
                r.extra_offset = OFFSET_BITS'(kk / (n - 1));
            end else begin
                // Parity walks down from the last disk; data skips over it
                stripe         = kk / (n - 1);
                pos            = kk % (n - 1);
                par            = n - 1 - (stripe % n);
                r.data_disk    = DISK_W'((pos < par) ? pos : pos + 1);
                r.data_offset  = OFFSET_BITS'(stripe);
                r.extra_kind   = KIND_PARITY;
                r.extra_disk   = DISK_W'(par);
                r.extra_offset = OFFSET_BITS'(stripe);
            end
        end
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            err_count++;
            if (err_count <= 100)
                $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Feed indexes from the queue in bursts with random gaps
    always @(negedge clk) begin
        if (!rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_taken) begin
            if (gap_left > 0 || index_queue.size() == 0) begin
                if (gap_left > 0) gap_left--;
                req_if.valid <= 1'b0;
            end else begin
                req_if.valid         <= 1'b1;
                req_if.logical_index <= index_queue.pop_front();
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
                end
            end
        end
    end

    // Stall the result side according to the phase's pattern
    always @(negedge clk) begin
        pattern_cnt++;
        if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
        end else begin
            case (stall_mode)
                READY_ALWAYS: begin
                    rsp_if.ready <= 1'b1;
                end
                READY_RANDOM: begin
                    rsp_if.ready <= ($urandom_range(0, 3) != 0);
                end
                READY_PERIODIC: begin
                    rsp_if.ready <= ((pattern_cnt % 11) >= 4);
                end
                default: begin
                    if ($urandom_range(0, 15) == 0) begin
                        stall_left = $urandom_range(5, 30);
                        rsp_if.ready <= 1'b0;
                    end else begin
                        rsp_if.ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    // Record accepted indexes and check each result against the oldest prediction
    always @(posedge clk) begin : monitor
        t_loc want;
        req_taken = 1'b0;
        if (rst_n) begin
            if (req_if.valid && req_if.ready) begin
                expected_locs.push_back(map_index(req_if.logical_index));
                n_accepted++;
                req_taken = 1'b1;
            end
            if (rsp_if.valid && rsp_if.ready) begin
                if (expected_locs.size() == 0) begin
                    err_count++;
                    if (err_count <= 100)
                        $display("%0t: result with none expected: expected nothing, got disk %0d",
                                 $time, rsp_if.data_disk);
                end else begin
                    want = expected_locs.pop_front();
                    check_field("in_range", 32'(want.in_range), 32'(rsp_if.in_range));
                    check_field("data_disk", 32'(want.data_disk), 32'(rsp_if.data_disk));
                    check_field("data_offset", 32'(want.data_offset),
                                32'(rsp_if.data_offset));
                    check_field("extra_kind", 32'(want.extra_kind), 32'(rsp_if.extra_kind));
                    check_field("extra_disk", 32'(want.extra_disk), 32'(rsp_if.extra_disk));
                    check_field("extra_offset", 32'(want.extra_offset),
                                32'(rsp_if.extra_offset));
                end
            end
        end
    end

    task automatic wait_idle();
        do @(negedge clk); while (n_accepted != n_queued || expected_locs.size() != 0);
        repeat (3) @(negedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_LAYOUT_MODE: layout_sh = data[MODE_W-1:0];
            CFG_DISK_COUNT:  disks_sh  = data[DISK_COUNT_W-1:0];
            CFG_DISK_SIZE:   size_sh   = data[DISK_SIZE_W-1:0];
            default:         count_sh  = data[DATA_COUNT_W-1:0];
        endcase
    endtask

    // Drain, then load a full layout; return at a rising edge ready to queue
    task automatic set_layout(logic [MODE_W-1:0] mode, int unsigned n,
                              int unsigned size, int unsigned cnt);
        wait_idle();
        cfg_write(CFG_LAYOUT_MODE, CFG_DATA_W'(mode));
        cfg_write(CFG_DISK_COUNT, CFG_DATA_W'(n));
        cfg_write(CFG_DISK_SIZE, CFG_DATA_W'(size));
        cfg_write(CFG_DATA_COUNT, CFG_DATA_W'(cnt));
        @(posedge clk);
    endtask

    task automatic queue_index(longint unsigned k);
        index_queue.push_back(LOGICAL_W'(k));
        n_queued++;
    endtask

    initial begin : stimulus
        int unsigned     ph, i, r, n, size, cnt;
        longint unsigned lim, lim24, k;
        logic [MODE_W-1:0] mode;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset layout holds no data, so nothing is in range
        queue_index(0);
        queue_index(24'hFFFFFF);

        // Mirror all at full disk size, edges of the range
        set_layout(MODE_MIRROR_ALL, 5, 1048576, 0);
        queue_index(0);
        queue_index(1048575);
        queue_index(1048576);
        queue_index(24'hFFFFFF);

        // Zero disk size
        set_layout(MODE_MIRROR_ALL, 2, 0, 1);
        queue_index(0);

        // Mirrored pairs on all disks; top index overflows the offset width
        set_layout(MODE_MIRROR_PAIRS, 16, 1, 1 << 24);
        queue_index(0);
        queue_index(7);
        queue_index(24'hFFFFFF);

        // Dedicated parity on the smallest array
        set_layout(MODE_DEDICATED, 2, 1048576, 32'h1FFFFFF);
        queue_index(0);
        queue_index(1);
        queue_index(24'hFFFFFF);

        // Rotating parity, disk count above the maximum, data count edge
        set_layout(MODE_ROTATE, 17, 1048576, 5);
        queue_index(0);
        queue_index(4);
        queue_index(5);

        // Rotating parity, disk count below the minimum
        set_layout(MODE_ROTATE, 1, 1048576, 1 << 24);
        queue_index(0);
        queue_index(1);
        queue_index(2);
        queue_index(3);
        queue_index(24'hFFFFFF);

        // Zero data count with zero disks
        set_layout(MODE_DEDICATED, 0, 1048576, 0);
        queue_index(1);

        // Mirrored pairs with the largest out-of-range disk count
        set_layout(MODE_MIRROR_PAIRS, 31, 1, 1);
        queue_index(0);
        queue_index(1);

        // Random layouts, mostly well-formed indexes within the range
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            mode = MODE_W'($urandom_range(0, 3));
            r = $urandom_range(0, 9);
            if (r < 7)       n = $urandom_range(2, 16);
            else if (r == 7) n = $urandom_range(0, 1);
            else if (r == 8) n = $urandom_range(17, 31);
            else             n = ($urandom_range(0, 1) != 0) ? 16 : 2;
            r = $urandom_range(0, 9);
            if (r == 0)      size = 0;
            else if (r < 3)  size = 1048576;
            else if (r == 3) size = $urandom_range(1, 64);
            else if (r == 4) size = 32'h1FFFFF;
            else if (r == 5) size = $urandom() & 32'h1FFFFF;
            else             size = $urandom_range(1, 1048576);
            r = $urandom_range(0, 9);
            if (r == 0)      cnt = 0;
            else if (r < 3)  cnt = 1 << 24;
            else if (r == 3) cnt = 32'h1FFFFFF;
            else if (r == 4) cnt = $urandom_range(1, 200);
            else             cnt = $urandom() & 32'h1FFFFFF;
            set_layout(mode, n, size, cnt);

            if (ph % 4 == 0) begin
                stall_mode = READY_ALWAYS;
                gap_max    = 0;
            end else begin
                stall_mode = t_ready_mode'($urandom_range(0, 3));
                gap_max    = ($urandom_range(0, 1) != 0) ? 3 : 8;
            end

            lim   = (layout_sh == MODE_MIRROR_ALL) ? 64'(size_sh) : 64'(count_sh);
            lim24 = (lim > (1 << 24)) ? (1 << 24) : lim;
            for (i = 0; i < PHASE_ITEMS; i++) begin
                // Hold the sender once mid-phase until every result is back
                if (ph == 5 && i == PHASE_ITEMS / 2) begin
                    wait_idle();
                    @(posedge clk);
                end
                r = $urandom_range(0, 9);
                if (r < 6 && lim24 > 0) k = {$urandom(), $urandom()} % lim24;
                else if (r == 6)        k = 64'($urandom_range(0, 63));
                else if (r == 7)        k = lim + 64'($urandom_range(0, 2)) - 1;
                else                    k = 64'($urandom() & 32'hFFFFFF);
                queue_index(k);
            end
        end

        // Drain, then allow the pipeline depth for any stray result
        wait_idle();
        repeat (LATENCY + 10) @(posedge clk);
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
